// ----- src/csc_pkg.sv -----
package csc_pkg;

    // number of cordic iterations in each of the two passes
    localparam int CORDIC_STAGES = 32;
    // register stages of the gain multiplier
    localparam int GAIN_STAGES = 3;
    // valid bits along the back pipeline: three gain units, two cordic passes, output stage
    localparam int PIPE_DEPTH = 3 * GAIN_STAGES + 2 * CORDIC_STAGES + 1;

    localparam int ANG_TAB_LEN = 48;

    typedef logic signed [63:0] dat_t;
    typedef logic signed [33:0] ang_t;

    localparam logic [31:0] INV_GAIN = 32'd2608131496;
    localparam ang_t QUARTER_TURN = 34'sd1073741824;
    localparam ang_t HALF_TURN = 34'sd2147483648;
    localparam dat_t RAD_MAX = 64'sd549755813887;
    localparam dat_t POS_MIN = -64'sd549755813888;
    localparam dat_t ROUND_HALF = 64'sd32768;

    localparam logic [31:0] ANG_TAB [ANG_TAB_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0,
        32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
        32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
    };

    typedef struct packed {
        logic              opcode;
        logic signed [39:0] pos_x;
        logic signed [39:0] pos_y;
        logic signed [39:0] pos_z;
        logic signed [31:0] in_longitude;
        logic signed [31:0] in_latitude;
        logic        [38:0] in_radius;
    } item_t;

    typedef struct packed {
        logic signed [39:0] out_x;
        logic signed [39:0] out_y;
        logic signed [39:0] out_z;
        logic signed [31:0] out_longitude;
        logic signed [31:0] out_latitude;
        logic        [38:0] out_radius;
        logic               degenerate;
    } result_t;

    // one item as it travels through the back pipeline
    typedef struct packed {
        logic               op;
        logic               skip;
        logic               deg;
        logic               neg2;
        logic signed [31:0] pre_lat;
        logic        [38:0] pre_rad;
        dat_t               x;
        dat_t               y;
        dat_t               z;
        ang_t               a;
        ang_t               w;
    } pipe_t;

    // metres to q16, sign extended
    function automatic dat_t pos_q16(logic [39:0] p);
        return {{8{p[39]}}, p, 16'h0000};
    endfunction

    function automatic ang_t ang_tab(logic [5:0] i);
        return ang_t'({2'b00, ANG_TAB[i]});
    endfunction

    // one micro-rotation; vectoring for opcode 0, rotation for opcode 1
    function automatic pipe_t cordic_step(pipe_t t, logic [5:0] i);
        pipe_t r;
        dat_t  dx;
        dat_t  dy;
        logic  up;
        r  = t;
        dx = t.x >>> i;
        dy = t.y >>> i;
        up = t.op ? (t.a >= 0) : (t.y < 0);
        if (up)
        begin
            r.x = t.x - dy;
            r.y = t.y + dx;
            r.a = t.a - ang_tab(i);
        end
        else
        begin
            r.x = t.x + dy;
            r.y = t.y - dx;
            r.a = t.a + ang_tab(i);
        end
        return r;
    endfunction

    function automatic dat_t round_q16(dat_t v);
        return (v + ROUND_HALF) >>> 16;
    endfunction

    function automatic logic [39:0] sat40(dat_t v);
        logic [39:0] r;
        if (v > RAD_MAX)
            r = 40'h7F_FFFF_FFFF;
        else if (v < POS_MIN)
            r = 40'h80_0000_0000;
        else
            r = v[39:0];
        return r;
    endfunction

endpackage

// ----- src/csc_gain.sv -----
module csc_gain (
    input  logic          clk,
    input  logic          en,
    input  csc_pkg::dat_t din,
    output csc_pkg::dat_t dout
);
    import csc_pkg::*;

    logic        neg1_reg;
    logic [63:0] mag_reg;
    logic        neg2_reg;
    logic [63:0] phi_reg;
    logic [31:0] plo_reg;
    dat_t        out_reg;

    logic [63:0] mag_next;
    logic [63:0] phi_next;
    logic [63:0] plo_full;
    logic [63:0] sum;
    dat_t        out_next;

    // magnitude, then two 32x32 partial products, then sum and sign
    always_comb
    begin
        mag_next = din[63] ? 64'(-din) : 64'(din);
        phi_next = mag_reg[63:32] * INV_GAIN;
        plo_full = mag_reg[31:0] * INV_GAIN;
        sum      = phi_reg + {32'h0, plo_reg};
        out_next = neg2_reg ? -dat_t'(sum) : dat_t'(sum);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= din[63];
            mag_reg  <= mag_next;
            neg2_reg <= neg1_reg;
            phi_reg  <= phi_next;
            plo_reg  <= plo_full[63:32];
            out_reg  <= out_next;
        end
    end

    assign dout = out_reg;

endmodule

// ----- src/csc_front.sv -----
module csc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  csc_pkg::item_t item,
    input  logic           push,
    output logic           full,
    output csc_pkg::pipe_t tok,
    output logic           tok_vld,
    input  logic           tok_pop
);
    import csc_pkg::*;

    pipe_t       q_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        wr_en;
    logic        rd_en;

    pipe_t       cls;
    dat_t        x16;
    dat_t        y16;
    dat_t        z16;
    dat_t        r16;
    logic [39:0] zabs;
    ang_t        lat;
    ang_t        lon;
    logic        neg1;

    // classify the beat: origin, polar axis, half-turn pre-rotation, angle reduction
    always_comb
    begin
        cls     = '0;
        cls.op  = item.opcode;
        x16     = pos_q16(item.pos_x);
        y16     = pos_q16(item.pos_y);
        z16     = pos_q16(item.pos_z);
        r16     = {9'h000, item.in_radius, 16'h0000};
        zabs    = item.pos_z[39] ? 40'(-item.pos_z) : 40'(item.pos_z);
        lat     = {{2{item.in_latitude[31]}}, item.in_latitude};
        lon     = {{2{item.in_longitude[31]}}, item.in_longitude};
        neg1    = 1'b0;
        if (!item.opcode)
        begin
            if (item.pos_x == '0 && item.pos_y == '0)
            begin
                cls.skip = 1'b1;
                if (item.pos_z == '0)
                    cls.deg = 1'b1;
                else
                begin
                    cls.pre_lat = item.pos_z[39] ? -32'sd1073741824 : 32'sd1073741824;
                    cls.pre_rad = zabs[39] ? '1 : zabs[38:0];
                    cls.deg     = zabs[39];
                end
            end
            else if (item.pos_x[39])
            begin
                cls.x = -x16;
                cls.y = -y16;
                cls.a = HALF_TURN;
            end
            else
            begin
                cls.x = x16;
                cls.y = y16;
            end
            cls.z = z16;
        end
        else
        begin
            if (item.in_radius == '0)
            begin
                cls.skip = 1'b1;
                cls.deg  = 1'b1;
            end
            if (lat > QUARTER_TURN)
            begin
                lat  = lat - HALF_TURN;
                neg1 = 1'b1;
            end
            else if (lat < -QUARTER_TURN)
            begin
                lat  = lat + HALF_TURN;
                neg1 = 1'b1;
            end
            if (lon > QUARTER_TURN)
            begin
                lon      = lon - HALF_TURN;
                cls.neg2 = 1'b1;
            end
            else if (lon < -QUARTER_TURN)
            begin
                lon      = lon + HALF_TURN;
                cls.neg2 = 1'b1;
            end
            cls.x = neg1 ? -r16 : r16;
            cls.a = lat;
            cls.w = lon;
        end
    end

    // two-entry queue toward the back pipeline
    assign full    = (cnt_reg == 2'd2);
    assign tok_vld = (cnt_reg != 2'd0);
    assign tok     = q_reg[rd_ptr_reg];
    assign wr_en   = push && !full;
    assign rd_en   = tok_pop && tok_vld;

    always_comb
    begin
        wr_ptr_next = wr_en ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            q_reg[wr_ptr_reg] <= cls;
    end

endmodule

// ----- src/csc_back.sv -----
module csc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  csc_pkg::pipe_t   in_tok,
    input  logic             in_vld,
    output logic             in_pop,
    output csc_pkg::result_t res,
    output logic             res_push,
    input  logic             res_ready
);
    import csc_pkg::*;

    localparam int CS = CORDIC_STAGES;

    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;
    logic                  adv;

    pipe_t   tok_g0_reg [GAIN_STAGES];
    pipe_t   tok_ca_reg [CS];
    pipe_t   tok_g1_reg [GAIN_STAGES];
    pipe_t   tok_cb_reg [CS];
    pipe_t   tok_g2_reg [GAIN_STAGES];
    result_t res_reg;
    result_t res_next;

    dat_t    g0_out;
    dat_t    g1_out;
    dat_t    g2_out;
    pipe_t   ca_in;
    pipe_t   cb_in;
    pipe_t   fin;
    dat_t    rad;
    ang_t    lat;

    // whole pipeline moves unless the finished beat cannot leave
    assign adv      = !vld_reg[PIPE_DEPTH-1] || res_ready;
    assign in_pop   = adv && in_vld;
    assign res_push = vld_reg[PIPE_DEPTH-1] && res_ready;
    assign res      = res_reg;
    assign vld_next = {vld_reg[PIPE_DEPTH-2:0], in_vld};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    csc_gain u_gain0 (.clk(clk), .en(adv), .din(in_tok.x), .dout(g0_out));
    csc_gain u_gain1 (.clk(clk), .en(adv), .din(tok_ca_reg[CS-1].x), .dout(g1_out));
    csc_gain u_gain2 (.clk(clk), .en(adv), .din(tok_cb_reg[CS-1].x), .dout(g2_out));

    // radius gain removal before the first pass for opcode 1
    always_comb
    begin
        ca_in = tok_g0_reg[GAIN_STAGES-1];
        if (ca_in.op)
            ca_in.x = g0_out;
    end

    // hand-over between the passes
    always_comb
    begin
        cb_in = tok_g1_reg[GAIN_STAGES-1];
        if (!cb_in.op)
        begin
            cb_in.x = g1_out;
            cb_in.y = tok_g1_reg[GAIN_STAGES-1].z;
            cb_in.a = '0;
            cb_in.w = tok_g1_reg[GAIN_STAGES-1].a;
        end
        else
        begin
            cb_in.x = tok_g1_reg[GAIN_STAGES-1].neg2 ? -g1_out : g1_out;
            cb_in.y = '0;
            cb_in.z = tok_g1_reg[GAIN_STAGES-1].y;
            cb_in.a = tok_g1_reg[GAIN_STAGES-1].w;
        end
    end

    // gain delay lines
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tok_g0_reg[0] <= in_tok;
            tok_g1_reg[0] <= tok_ca_reg[CS-1];
            tok_g2_reg[0] <= tok_cb_reg[CS-1];
            for (int k = 1; k < GAIN_STAGES; k++)
            begin
                tok_g0_reg[k] <= tok_g0_reg[k-1];
                tok_g1_reg[k] <= tok_g1_reg[k-1];
                tok_g2_reg[k] <= tok_g2_reg[k-1];
            end
            res_reg <= res_next;
        end
    end

    // the two cordic passes, one iteration per register stage
    for (genvar k = 0; k < CS; k++)
    begin : g_cordic
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    tok_ca_reg[k] <= cordic_step(ca_in, 6'(k));
                    tok_cb_reg[k] <= cordic_step(cb_in, 6'(k));
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    tok_ca_reg[k] <= cordic_step(tok_ca_reg[k-1], 6'(k));
                    tok_cb_reg[k] <= cordic_step(tok_cb_reg[k-1], 6'(k));
                end
            end
        end
    end

    // rounding, clamping and saturation of the result
    always_comb
    begin
        fin      = tok_g2_reg[GAIN_STAGES-1];
        res_next = '0;
        rad      = round_q16(g2_out);
        lat      = fin.a;
        if (lat > QUARTER_TURN)
            lat = QUARTER_TURN;
        else if (lat < -QUARTER_TURN)
            lat = -QUARTER_TURN;
        if (fin.skip)
        begin
            res_next.out_latitude = fin.pre_lat;
            res_next.out_radius   = fin.pre_rad;
            res_next.degenerate   = fin.deg;
        end
        else if (!fin.op)
        begin
            res_next.out_longitude = fin.w[31:0];
            res_next.out_latitude  = lat[31:0];
            if (rad > RAD_MAX)
            begin
                res_next.out_radius = '1;
                res_next.degenerate = 1'b1;
            end
            else
                res_next.out_radius = rad[38:0];
        end
        else
        begin
            res_next.out_x = sat40(round_q16(fin.x));
            res_next.out_y = sat40(round_q16(fin.y));
            res_next.out_z = sat40(round_q16(fin.z));
        end
    end

endmodule

// ----- src/cartesian_spherical_converter.sv -----
// channel  direction  handshake           payload
// item     in         push / full         csc_pkg::item_t
// result   out        pop / empty         csc_pkg::result_t
//
// one item per cycle sustained while results are popped; a result shows on the ports
// once its item has passed the input queue, the back pipeline and the result queue
// the back pipeline holds the two cordic passes (one iteration per stage) and three
// gain multipliers of three stages each
// rst_n clears queue pointers, queue counts and pipeline valid bits only
// a held result stalls the whole back pipeline; the input queue then fills
module cartesian_spherical_converter (
    input  logic             clk,
    input  logic             rst_n,
    input  csc_pkg::item_t   item,
    input  logic             push,
    output logic             full,
    output csc_pkg::result_t result,
    output logic             empty,
    input  logic             pop
);
    import csc_pkg::*;

    pipe_t      tok;
    logic       tok_vld;
    logic       tok_pop;
    result_t    bk_res;
    logic       bk_push;
    logic       oq_ready;

    result_t    oq_reg [2];
    logic       oq_wr_reg;
    logic       oq_wr_next;
    logic       oq_rd_reg;
    logic       oq_rd_next;
    logic [1:0] oq_cnt_reg;
    logic [1:0] oq_cnt_next;
    logic       oq_pop;

    csc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .push    (push),
        .full    (full),
        .tok     (tok),
        .tok_vld (tok_vld),
        .tok_pop (tok_pop)
    );

    csc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tok    (tok),
        .in_vld    (tok_vld),
        .in_pop    (tok_pop),
        .res       (bk_res),
        .res_push  (bk_push),
        .res_ready (oq_ready)
    );

    // two-entry result queue
    assign oq_ready = (oq_cnt_reg != 2'd2);
    assign empty    = (oq_cnt_reg == 2'd0);
    assign result   = oq_reg[oq_rd_reg];
    assign oq_pop   = pop && !empty;

    always_comb
    begin
        oq_wr_next  = bk_push ? !oq_wr_reg : oq_wr_reg;
        oq_rd_next  = oq_pop ? !oq_rd_reg : oq_rd_reg;
        oq_cnt_next = oq_cnt_reg + 2'(bk_push) - 2'(oq_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= 1'b0;
            oq_rd_reg  <= 1'b0;
            oq_cnt_reg <= 2'd0;
        end
        else
        begin
            oq_wr_reg  <= oq_wr_next;
            oq_rd_reg  <= oq_rd_next;
            oq_cnt_reg <= oq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bk_push)
            oq_reg[oq_wr_reg] <= bk_res;
    end

    // result queue never overfills
    a_oq_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        oq_cnt_reg != 2'd3)
        else $error("result queue count out of range");

    // a beat carries either cartesian or spherical results, never both
    a_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.out_radius == '0 ||
                    (result.out_x == '0 && result.out_y == '0 && result.out_z == '0)))
        else $error("mixed cartesian and spherical results");

    // latitude stays within a quarter turn
    a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.out_latitude <= 32'sd1073741824 &&
                    result.out_latitude >= -32'sd1073741824))
        else $error("latitude out of range");

endmodule
